>>> hdl/sfs_pkg.sv
// Shared constants, types and codes for the sorted floor search core.
`timescale 1ns / 1ps
package sfs_pkg;

    // Storage geometry and key format.
    localparam int DEPTH     = 1024;
    localparam int KEY_WIDTH = 32;
    localparam int IDX_W     = $clog2(DEPTH);
    localparam int LEN_W     = IDX_W + 1;
    localparam int POS_W     = 11;
    localparam int VAL_W     = 32;

    typedef logic signed [KEY_WIDTH-1:0] t_key;
    typedef logic [IDX_W-1:0]            t_idx;
    typedef logic signed [IDX_W+1:0]     t_sidx;
    typedef logic [LEN_W-1:0]            t_len;
    typedef logic [POS_W-1:0]            t_pos;

    // Operation codes of an input word.
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_WRITTEN  = 3'd0,
        ST_HIT      = 3'd1,
        ST_SMALLER  = 3'd2,
        ST_NONE     = 3'd3,
        ST_BADRANGE = 3'd4
    } t_status;

    // Controller states.
    typedef enum logic {
        S_IDLE  = 1'b0,
        S_PROBE = 1'b1
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic wr;
        logic search;
        logic probe;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
        logic start_ok;
        logic more;
    } t_dp_status;

endpackage

>>> hdl/sorted_floor_search_core.sv
// Top level of the sorted floor search core: controller plus datapath.
//
//  Channel | Handshake                   | Word
//  --------+-----------------------------+-----------------------------------------
//  input   | i_in_valid / o_in_ready     | opcode, element index and value, target,
//          |                             | left and right bound
//  result  | o_out_valid / i_out_ready   | status, position
//  config  | i_cfg_we (no wait)          | array length
//
// Writes can follow each other every cycle as long as i_out_ready is held high.
// A search has one set-up step and then at most eleven probes for 1024 entries;
// the single memory port with its registered read allows only one probe per
// cycle.
// Reset is synchronous and active low; it clears control state and sets the length
// to 1024. The key memory is not cleared and must be written before it is searched.
// A stalled result waits in the output register; the next word is taken once that
// register is being emptied.
`timescale 1ns / 1ps
module sorted_floor_search_core
    import sfs_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic                    i_opcode,
    input  logic [IDX_W-1:0]        i_element_index,
    input  logic signed [VAL_W-1:0] i_element_value,
    input  logic signed [VAL_W-1:0] i_target_value,
    input  logic [IDX_W-1:0]        i_left_bound,
    input  logic [IDX_W-1:0]        i_right_bound,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [2:0]              o_status,
    output logic [POS_W-1:0]        o_position,
    input  logic                    i_cfg_we,
    input  logic [LEN_W-1:0]        i_cfg_wdata
);

    t_cmd       cmd;
    t_dp_status dp_status;

    // Sequencer.
    sfs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_opcode   (i_opcode),
        .i_status   (dp_status),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    // Memory, comparator and result register.
    sfs_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (dp_status),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_element_index (i_element_index),
        .i_element_value (i_element_value),
        .i_target_value  (i_target_value),
        .i_left_bound    (i_left_bound),
        .i_right_bound   (i_right_bound),
        .i_out_ready     (i_out_ready),
        .o_out_valid     (o_out_valid),
        .o_status_code   (o_status),
        .o_position      (o_position)
    );

endmodule

>>> hdl/sfs_ctrl.sv
// Controller state machine for the sorted floor search core.
`timescale 1ns / 1ps
module sfs_ctrl
    import sfs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_opcode,
    input  t_dp_status i_status,
    output logic       o_in_ready,
    output t_cmd       o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   accept;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Outputs: a word is taken only out of reset, when idle and when the result register
    // will be free.
    always_comb begin
        o_in_ready   = i_rst_n && (r_state == S_IDLE) && i_status.out_free;
        accept       = i_in_valid && o_in_ready;
        o_cmd.wr     = accept && (i_opcode == OP_WRITE);
        o_cmd.search = accept && (i_opcode == OP_SEARCH);
        o_cmd.probe  = (r_state == S_PROBE);
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (o_cmd.search && i_status.start_ok) begin
                    n_state = S_PROBE;
                end
            end
            S_PROBE: begin
                if (!i_status.more) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // The search loop ends exactly when the datapath reports no further probe.
    a_probe_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROBE) && !i_status.more |=> (r_state == S_IDLE))
        else $error("probe loop did not return to idle");

    // A search with a good range always enters the probe loop.
    a_probe_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.search && i_status.start_ok |=> (r_state == S_PROBE))
        else $error("valid search did not start probing");

    // No word is taken while a search is probing.
    a_busy_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROBE) |-> !o_in_ready)
        else $error("input taken during a search");

endmodule

>>> hdl/sfs_datapath.sv
// Key memory, search bounds, comparator and result register of the search core.
`timescale 1ns / 1ps
module sfs_datapath
    import sfs_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cmd                    i_cmd,
    output t_dp_status              o_status,
    input  logic                    i_cfg_we,
    input  logic [LEN_W-1:0]        i_cfg_wdata,
    input  logic [IDX_W-1:0]        i_element_index,
    input  logic signed [VAL_W-1:0] i_element_value,
    input  logic signed [VAL_W-1:0] i_target_value,
    input  logic [IDX_W-1:0]        i_left_bound,
    input  logic [IDX_W-1:0]        i_right_bound,
    input  logic                    i_out_ready,
    output logic                    o_out_valid,
    output logic [2:0]              o_status_code,
    output logic [POS_W-1:0]        o_position
);

    t_key    r_mem [DEPTH];
    t_key    r_rdata;
    t_key    r_target;
    t_len    r_len;
    t_sidx   r_left;
    t_sidx   r_right;
    t_idx    r_mid;
    t_idx    r_found;
    logic    r_found_v;
    logic    r_out_valid;
    t_status r_out_status;
    t_pos    r_out_pos;

    t_len    len_eff;
    t_len    right_c;
    t_len    mid0_sum;
    t_idx    mid0;
    logic    bad;
    logic    eq;
    logic    lt;
    t_sidx   n_left;
    t_sidx   n_right;
    t_sidx   n_sum;
    t_idx    n_mid;
    t_idx    n_found;
    logic    n_found_v;
    logic    more;
    t_idx    mem_addr;
    logic    rd_en;

    // Length register, taken as at least one and at most the memory depth.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= t_len'(DEPTH);
        end else if (i_cfg_we) begin
            r_len <= i_cfg_wdata;
        end
    end

    always_comb begin
        if (r_len == '0) begin
            len_eff = t_len'(1);
        end else if (r_len > t_len'(DEPTH)) begin
            len_eff = t_len'(DEPTH);
        end else begin
            len_eff = r_len;
        end
    end

    // Range set-up for a new search: clamp the right bound and pick the first midpoint.
    always_comb begin
        if ({1'b0, i_right_bound} >= len_eff) begin
            right_c = len_eff - t_len'(1);
        end else begin
            right_c = {1'b0, i_right_bound};
        end
        bad      = {1'b0, i_left_bound} > right_c;
        mid0_sum = {1'b0, i_left_bound} + right_c;
        mid0     = mid0_sum[IDX_W:1];
    end

    // One probe: compare the fetched key and narrow the range.
    always_comb begin
        eq        = (r_rdata == r_target);
        lt        = (r_rdata < r_target);
        n_left    = lt ? (t_sidx'({1'b0, r_mid}) + t_sidx'(1)) : r_left;
        n_right   = (!lt && !eq) ? (t_sidx'({1'b0, r_mid}) - t_sidx'(1)) : r_right;
        n_found_v = r_found_v || lt || eq;
        n_found   = (lt || eq) ? r_mid : r_found;
        more      = !eq && (n_left <= n_right);
        n_sum     = n_left + n_right;
        n_mid     = n_sum[IDX_W:1];
    end

    // Single memory port: writes at the element index, reads at the first or next midpoint.
    always_comb begin
        rd_en = i_cmd.search || (i_cmd.probe && more);
        if (i_cmd.wr) begin
            mem_addr = i_element_index;
        end else if (i_cmd.search) begin
            mem_addr = mid0;
        end else begin
            mem_addr = n_mid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            r_mem[mem_addr] <= t_key'(i_element_value);
        end
        if (rd_en) begin
            r_rdata <= r_mem[mem_addr];
        end
    end

    // Search registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.search) begin
            r_target  <= t_key'(i_target_value);
            r_left    <= t_sidx'({1'b0, i_left_bound});
            r_right   <= t_sidx'(right_c);
            r_mid     <= mid0;
            r_found   <= '0;
            r_found_v <= 1'b0;
        end else if (i_cmd.probe) begin
            r_left    <= n_left;
            r_right   <= n_right;
            r_mid     <= n_mid;
            r_found   <= n_found;
            r_found_v <= n_found_v;
        end
    end

    // Result register: loaded on a write, a bad range or the last probe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.wr || (i_cmd.search && bad) || (i_cmd.probe && !more)) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            r_out_status <= ST_WRITTEN;
            r_out_pos    <= '0;
        end else if (i_cmd.search && bad) begin
            r_out_status <= ST_BADRANGE;
            r_out_pos    <= '0;
        end else if (i_cmd.probe && !more) begin
            if (eq) begin
                r_out_status <= ST_HIT;
                r_out_pos    <= t_pos'({1'b0, n_found}) + t_pos'(1);
            end else if (n_found_v) begin
                r_out_status <= ST_SMALLER;
                r_out_pos    <= t_pos'({1'b0, n_found}) + t_pos'(1);
            end else begin
                r_out_status <= ST_NONE;
                r_out_pos    <= '0;
            end
        end
    end

    always_comb begin
        o_status.out_free = !r_out_valid || i_out_ready;
        o_status.start_ok = !bad;
        o_status.more     = more;
        o_out_valid       = r_out_valid;
        o_status_code     = r_out_status;
        o_position        = r_out_pos;
    end

    // A probe only ever runs on a non-empty range.
    a_range_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.probe |-> (r_left <= r_right))
        else $error("probe issued on an empty range");

    // A bad range reports its status in the following cycle.
    a_bad_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.search && bad |=> r_out_valid && (r_out_status == ST_BADRANGE))
        else $error("bad range not reported");

    // A hit or a smaller element always carries a non-zero position.
    a_pos_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && ((r_out_status == ST_HIT) || (r_out_status == ST_SMALLER))
        |-> (r_out_pos != '0))
        else $error("found result without a position");

endmodule
